>>> src/pbb_pkg.sv
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared types and constants for the packed bit-field buffer.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int WORD_BITS = 32;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEN   = 2'd1;
  localparam logic [1:0] ST_PAST_END  = 2'd2;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS
  } pbb_state_t;

endpackage

>>> src/pbb_bank.sv
// ----------------------------------------------------------------------------
// pbb_bank
// One bank of the word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pbb_bank #(
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/packed_bitfield_buffer_unit.sv
// ----------------------------------------------------------------------------
// packed_bitfield_buffer_unit
// Big-endian bit-field extract and insert over a store of 32-bit words.
//
//   channel | direction | handshake          | payload
//   in      | into unit | in_valid/in_stall  | kind, field_length, bit_position,
//           |           |                    | write_value
//   out     | from unit | out_valid/out_stall| read_value, status
//
// Each word is handled in two steps: the accept cycle issues reads to the even and
// odd banks, and the access state that follows merges, writes back and loads
// the result from the registered bank reads.
// After reset a clearing pass zeroes the banks; no word is accepted meanwhile.
// A stalled result holds the unit in its access cycle until taken.
// ----------------------------------------------------------------------------
module packed_bitfield_buffer_unit
  import pbb_pkg::*;
#(
  parameter int STORE_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [5:0]  field_length,
  input  logic [7:0]  bit_position,
  input  logic [31:0] write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_value,
  output logic [1:0]  status
);

  localparam int MEM_WORDS  = (STORE_WORDS < 9) ? STORE_WORDS : 9;
  localparam int EVEN_DEPTH = (MEM_WORDS + 1) / 2;
  localparam int ODD_DEPTH  = MEM_WORDS / 2;
  localparam int EAW        = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
  localparam int OAW        = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
  localparam logic [15:0] TOTAL_BITS = 16'(WORD_BITS * STORE_WORDS);

  pbb_state_t state, state_next;
  logic accept, fire;

  logic [EAW-1:0] clr_cnt;
  logic           clr_last;

  logic [2:0]  idx;
  logic [3:0]  hi_word, lo_word, even_word, odd_word;
  logic        has_next;
  logic [8:0]  pos_end;
  logic [1:0]  status_in;

  logic        r_kind;
  logic [5:0]  r_len;
  logic [4:0]  r_off;
  logic        r_odd;
  logic        r_has_next;
  logic [31:0] r_val;
  logic [1:0]  r_status;
  logic [EAW-1:0] r_even_addr;
  logic [OAW-1:0] r_odd_addr;

  logic          even_we, odd_we, even_re, odd_re;
  logic [EAW-1:0] even_waddr;
  logic [OAW-1:0] odd_waddr;
  logic [31:0]   even_wdata, odd_wdata, even_q, odd_q;

  logic [31:0] hi, lo, mask, field;
  logic [63:0] win, win_new, mask_sh;
  logic [6:0]  shift;
  logic        do_write;

  // decode
  always_comb begin
    idx       = bit_position[7:5];
    hi_word   = {1'b0, idx};
    lo_word   = 4'({1'b0, idx} + 4'd1);
    even_word = idx[0] ? lo_word : hi_word;
    odd_word  = idx[0] ? hi_word : lo_word;
    has_next  = (int'(idx) + 1) < STORE_WORDS;
    pos_end   = {1'b0, bit_position} + {3'b000, field_length};
    if (field_length == 6'd0 || field_length > 6'd32) begin
      status_in = ST_BAD_LEN;
    end else if ({7'b0, pos_end} > TOTAL_BITS) begin
      status_in = ST_PAST_END;
    end else begin
      status_in = ST_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_last) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_ACCESS;
      S_ACCESS: if (fire) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall = (state != S_IDLE);
    accept   = in_valid && (state == S_IDLE);
    fire     = (state == S_ACCESS) && (!out_valid || !out_stall);
    clr_last = (state == S_CLEAR) && (clr_cnt == EAW'(EVEN_DEPTH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= EAW'(clr_cnt + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_kind      <= kind;
      r_len       <= field_length;
      r_off       <= bit_position[4:0];
      r_odd       <= idx[0];
      r_has_next  <= has_next;
      r_val       <= write_value;
      r_status    <= status_in;
      r_even_addr <= EAW'(even_word >> 1);
      r_odd_addr  <= OAW'(odd_word >> 1);
    end
  end

  // merge
  always_comb begin
    hi      = r_odd ? odd_q : even_q;
    lo      = r_has_next ? (r_odd ? even_q : odd_q) : 32'd0;
    win     = {hi, lo};
    mask    = ALL_ONES >> (6'd32 - r_len);
    shift   = 7'd64 - {2'b00, r_off} - {1'b0, r_len};
    field   = 32'(win >> shift) & mask;
    mask_sh = {32'd0, mask} << shift;
    win_new = (win & ~mask_sh) | ({32'd0, r_val & mask} << shift);
    do_write = fire && (r_kind == KIND_WRITE) && (r_status == ST_OK);
  end

  // bank ports
  always_comb begin
    even_re = accept && (status_in == ST_OK) && (!idx[0] || has_next);
    odd_re  = accept && (status_in == ST_OK) && (idx[0] || has_next);
    if (state == S_CLEAR) begin
      even_we    = 1'b1;
      even_waddr = clr_cnt;
      even_wdata = 32'd0;
      odd_we     = int'(clr_cnt) < ODD_DEPTH;
      odd_waddr  = OAW'(clr_cnt);
      odd_wdata  = 32'd0;
    end else begin
      even_we    = do_write && (!r_odd || r_has_next);
      even_waddr = r_even_addr;
      even_wdata = r_odd ? win_new[31:0] : win_new[63:32];
      odd_we     = do_write && (r_odd || r_has_next);
      odd_waddr  = r_odd_addr;
      odd_wdata  = r_odd ? win_new[63:32] : win_new[31:0];
    end
  end

  pbb_bank #(.DEPTH(EVEN_DEPTH), .AW(EAW)) u_even (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .re    (even_re),
    .raddr (EAW'(even_word >> 1)),
    .rdata (even_q)
  );

  pbb_bank #(.DEPTH(ODD_DEPTH), .AW(OAW)) u_odd (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .re    (odd_re),
    .raddr (OAW'(odd_word >> 1)),
    .rdata (odd_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status     <= r_status;
      read_value <= (r_status == ST_OK && r_kind == KIND_READ) ? field : 32'd0;
    end
  end

`ifndef SYNTHESIS
  a_no_bad_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_BAD_LEN || status == ST_PAST_END))
    else $error("result status has an undefined code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (read_value == 32'd0))
    else $error("failed access returned a nonzero value");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    (even_we || odd_we) |-> (state == S_CLEAR || state == S_ACCESS))
    else $error("bank written outside clear or access");

  a_access_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_ACCESS))
    else $error("accepted word did not enter access");
`endif

endmodule

>>> tb/tb_packed_bitfield_buffer_unit.sv
// ----------------------------------------------------------------------------
// tb_packed_bitfield_buffer_unit
// Self-checking bench for the big-endian bit-field extract/insert unit. A
// shadow copy of the word store predicts every read and write at the moment
// the word is taken. Results are checked in order against that prediction.
// Stimulus starts with directed corner fields: bad lengths, fields past the
// end, straddles and the last word. Random fields follow, with idle and stall
// bursts on both channels and one long receiver hold-off that backs up the
// input.
// ----------------------------------------------------------------------------
module tb_packed_bitfield_buffer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pbb_pkg::*;

  localparam int NWORDS       = 8;
  localparam int STORE_BITS   = NWORDS * WORD_BITS;
  localparam int RANDOM_ITEMS = 1025;
  localparam int CALM_TAIL    = 120;
  localparam int PRESSURE_AT  = 200;
  localparam int HOLD_OFF     = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic        kind;
    logic [5:0]  len;
    logic [7:0]  pos;
    logic [31:0] value;
  } access_t;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = KIND_READ;
  logic [5:0]  field_length = 6'd0;
  logic [7:0]  bit_position = 8'd0;
  logic [31:0] write_value = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_value;
  logic [1:0]  status;

  access_t     pending_words[$];
  result_t     expected_results[$];
  access_t     current_word;
  logic [31:0] shadow_store [NWORDS];
  int          send_gap = 0;
  int          stall_left = 0;
  bit          pressure_done = 1'b0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  int          errors = 0;

  packed_bitfield_buffer_unit #(
    .STORE_WORDS(NWORDS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .field_length(field_length),
    .bit_position(bit_position),
    .write_value(write_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(read_value),
    .status(status)
  );

  always #1 clk = ~clk;

  function automatic result_t field_access(access_t a);
    result_t         r;
    logic [2:0]      idx;
    int unsigned     off;
    int unsigned     shift;
    logic [63:0]     win;
    logic [63:0]     mask;
    logic            has_next;
    r.data   = 32'd0;
    r.status = ST_OK;
    if (a.len < 1 || a.len > WORD_BITS) begin
      r.status = ST_BAD_LEN;
    end else if (int'(a.pos) + int'(a.len) > STORE_BITS) begin
      r.status = ST_PAST_END;
    end else begin
      idx      = a.pos[7:5];
      off      = 32'(a.pos[4:0]);
      has_next = (int'(idx) + 1) < NWORDS;
      win      = {shadow_store[idx], 32'd0};
      if (has_next) win[31:0] = shadow_store[idx + 3'd1];
      shift = 64 - off - 32'(a.len);
      mask  = (64'd1 << a.len) - 64'd1;
      if (a.kind == KIND_READ) begin
        r.data = 32'((win >> shift) & mask);
      end else begin
        win = (win & ~(mask << shift)) | (({32'd0, a.value} & mask) << shift);
        shadow_store[idx] = win[63:32];
        if (has_next) shadow_store[idx + 3'd1] = win[31:0];
      end
    end
    return r;
  endfunction

  task automatic add_access(logic k, int len, int pos, logic [31:0] value);
    access_t a;
    a.kind  = k;
    a.len   = 6'(len);
    a.pos   = 8'(pos);
    a.value = value;
    pending_words.push_back(a);
  endtask

  // driver: hold word while stalled, advance on accept
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_results.push_back(field_access(current_word));
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        current_word = pending_words.pop_front();
        in_valid     <= 1'b1;
        kind         <= current_word.kind;
        field_length <= current_word.len;
        bit_position <= current_word.pos;
        write_value  <= current_word.value;
        if (pending_words.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result read_value %h status %0d", $time,
                   read_value, status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $display("%0t status expected %0d actual %0d", $time, exp_r.status, status);
            errors++;
          end
          if (read_value !== exp_r.data) begin
            $display("%0t read_value expected %h actual %h", $time, exp_r.data,
                     read_value);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
        stall_left    = HOLD_OFF;
        pressure_done = 1'b1;
      end else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("packed_bitfield_buffer_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int choice;
    int len;
    int pos;
    int count;
    logic k;
    logic [31:0] value;

    shadow_store = '{default: 32'd0};

    add_access(KIND_READ, 0, 0, 32'd0);
    add_access(KIND_WRITE, 0, 0, ALL_ONES);
    add_access(KIND_READ, 33, 0, 32'd0);
    add_access(KIND_WRITE, 63, 255, ALL_ONES);
    add_access(KIND_READ, 32, 0, 32'd0);
    add_access(KIND_WRITE, 32, 0, ALL_ONES);
    add_access(KIND_READ, 32, 0, 32'd0);
    add_access(KIND_WRITE, 8, 28, 32'h0000_00A5);
    add_access(KIND_READ, 8, 28, 32'd0);
    add_access(KIND_READ, 32, 16, 32'd0);
    add_access(KIND_WRITE, 5, 40, 32'hFFFF_FFE5);
    add_access(KIND_READ, 12, 36, 32'd0);
    add_access(KIND_WRITE, 32, 224, 32'h89AB_CDEF);
    add_access(KIND_READ, 32, 224, 32'd0);
    add_access(KIND_WRITE, 32, 225, ALL_ONES);
    add_access(KIND_READ, 2, 255, 32'd0);
    add_access(KIND_READ, 1, 255, 32'd0);
    add_access(KIND_WRITE, 1, 255, 32'd0);
    add_access(KIND_READ, 6, 250, 32'd0);
    add_access(KIND_WRITE, 32, 31, 32'h1234_5678);
    add_access(KIND_READ, 32, 31, 32'd0);
    add_access(KIND_READ, 1, 31, 32'd0);
    add_access(KIND_WRITE, 32, 255, ALL_ONES);
    add_access(KIND_READ, 32, 128, 32'd0);

    count = 0;
    while (count < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      k      = 1'($urandom_range(0, 1));
      value  = $urandom;
      if (choice < 7) begin
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(33, 63);
        pos = $urandom_range(0, 255);
      end else if (choice < 15) begin
        len = $urandom_range(2, 32);
        pos = $urandom_range(257 - len, 255);
      end else begin
        len = $urandom_range(1, 32);
        pos = $urandom_range(0, STORE_BITS - len);
      end
      add_access(k, len, pos, value);
      count++;
      if (choice >= 15 && k == KIND_WRITE && $urandom_range(0, 4) == 0) begin
        add_access(KIND_READ, len, pos, $urandom);
        count++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("packed_bitfield_buffer_unit: match");
    end else begin
      $display("packed_bitfield_buffer_unit: mismatch");
    end
    $finish;
  end

endmodule
